// ----- rtl/lsps_pkg.sv -----
// ============================================================================
// lsps_pkg: shared types and codes for the limited-slot preemptive scheduler
// Holds the action, event and register codes and the sequencer state type.
// ============================================================================
`default_nettype none
package lsps_pkg;
    localparam int TIME_W = 17;
    localparam int DEV_W  = 4;
    localparam int PRIO_W = 8;

    typedef enum logic [1:0] {
        ACT_PRIO = 2'd0,
        ACT_ADD  = 2'd1,
        ACT_ARM  = 2'd2,
        ACT_TICK = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        EV_OFF  = 2'd0,
        EV_ON   = 2'd1,
        EV_NONE = 2'd2
    } t_event;

    localparam logic [0:0] REG_RUN_LIMIT = 1'd0;
    localparam logic [0:0] REG_POLICY    = 1'd1;

    typedef struct packed {
        logic [DEV_W-1:0]  dev;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] stop;
    } t_win;

    typedef struct packed {
        logic [1:0]       ev;
        logic [DEV_W-1:0] dev;
        logic             last;
    } t_res;

    typedef struct packed {
        logic [1:0]        action;
        logic [DEV_W-1:0]  device;
        logic [PRIO_W-1:0] priority_req;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [TIME_W-1:0] now_time;
    } t_req;

    typedef struct packed {
        logic       idx;
        logic [3:0] data;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CMP,
        S_ADD_SH_RD,
        S_ADD_SH_WR,
        S_ARM_RD,
        S_ARM_CHK,
        S_RUN_RD,
        S_RUN_CHK,
        S_RSH_RD,
        S_RSH_WR,
        S_ACT_RD,
        S_ACT_CHK,
        S_PEND_RD,
        S_PEND_CHK,
        S_VIC_RD,
        S_VIC_CHK,
        S_PREEMPT,
        S_PSH_RD,
        S_PSH_WR,
        S_EMIT,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// ----- rtl/lsps_if.sv -----
// ============================================================================
// lsps_if: valid/ready channel
// Carries one item of type T between a source and a sink.
// ============================================================================
`default_nettype none
interface lsps_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/limited_slot_preemptive_scheduler.sv -----
// ============================================================================
// limited_slot_preemptive_scheduler: window table scheduler with preemption
// Switches devices on and off from a sorted table of activation windows.
// ============================================================================
// One item is handled at a time by a sequencer around three synchronous
// memories (window table, running list, pending list), each with a
// registered read; every list walk reads an entry, then acts on it. A
// priority set leaves the sequencer idle. An arm walks the table to the
// first window that has not yet ended. An add searches for the first
// greater entry, then shifts every entry from there up by one place. A
// tick retires ended running windows, moves activations to the pending
// list, then handles each pending entry, with a victim search when the
// running list is full and a list shift per removal. Each result item is
// held back in a staging register until the next one is known, so that the
// final item of a tick can carry last; it then moves to the output register.
// The sequencer waits when both registers are full, and at the end of a
// tick when the output register is full. No clearing pass is needed after
// reset. Configuration writes are taken at once; apply them only while idle.
`default_nettype none
module limited_slot_preemptive_scheduler #(
    parameter int MAX_WINDOWS = 16,
    parameter int MAX_RUNNING = 8,
    parameter int MAX_DEVICES = 16
) (
    input  wire i_clk,
    input  wire i_rst_n,
    lsps_if.sink   i_req,
    lsps_if.sink   i_cfg,
    lsps_if.source o_res
);
    localparam int WA = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int WC = $clog2(MAX_WINDOWS + 1);
    localparam int RA = (MAX_RUNNING > 1) ? $clog2(MAX_RUNNING) : 1;
    localparam int RC = $clog2(MAX_RUNNING + 1);
    localparam int DA = $clog2(MAX_DEVICES);
    localparam int TW = lsps_pkg::TIME_W;
    localparam int PW = lsps_pkg::PRIO_W;

    // ---- memories ---------------------------------------------------------
    lsps_pkg::t_win m_win  [MAX_WINDOWS];
    lsps_pkg::t_win m_run  [MAX_RUNNING];
    lsps_pkg::t_win m_pend [MAX_WINDOWS];
    // device priorities are MAX_DEVICES registers with resettable contents
    logic [PW-1:0]  r_prio [MAX_DEVICES];

    logic [WA-1:0]  w_raddr, w_waddr;
    logic           w_we;
    lsps_pkg::t_win w_wdata, r_wq;
    logic [RA-1:0]  run_raddr, run_waddr;
    logic           run_we;
    lsps_pkg::t_win run_wdata, r_rq;
    logic [WA-1:0]  p_raddr, p_waddr;
    logic           p_we;
    lsps_pkg::t_win p_wdata, r_pq;

    always_ff @(posedge i_clk) begin
        if (w_we) m_win[w_waddr] <= w_wdata;
        r_wq <= m_win[w_raddr];
        if (run_we) m_run[run_waddr] <= run_wdata;
        r_rq <= m_run[run_raddr];
        if (p_we) m_pend[p_waddr] <= p_wdata;
        r_pq <= m_pend[p_raddr];
    end

    // ---- control state ----------------------------------------------------
    lsps_pkg::t_state r_state, n_state;
    lsps_pkg::t_req   r_req, n_req;
    logic [3:0]    r_limit;
    logic          r_policy;
    logic [WC-1:0] r_wcnt, n_wcnt;
    logic [WA-1:0] r_next, n_next;
    logic [RC-1:0] r_rcnt, n_rcnt;
    logic [WC-1:0] r_pcnt, n_pcnt;
    logic [WC-1:0] r_i, n_i;        // general walk index
    logic [WC-1:0] r_j, n_j;        // shift index
    logic [RC-1:0] r_v, n_v;        // victim index
    logic [PW-1:0] r_vkey_p, n_vkey_p;
    logic [TW-1:0] r_vkey_t, n_vkey_t;
    lsps_pkg::t_win r_cur, n_cur;   // pending entry being handled
    lsps_pkg::t_win r_vic, n_vic;
    lsps_pkg::t_state r_ret, n_ret; // where to go after a shift
    logic          r_shrun, n_shrun;// running list shift vs pending shift
    logic          r_ov, n_ov;
    lsps_pkg::t_res r_out, n_out;   // output register
    lsps_pkg::t_res r_evt, n_evt;   // result just produced by the walk
    lsps_pkg::t_res r_stg, n_stg;   // held result, last not yet known
    logic          r_stg_v, n_stg_v;// a result of this tick is held
    logic          r_pset;
    logic [DA-1:0] r_pdev;
    logic [PW-1:0] r_pval;

    logic [RC-1:0] lim;
    assign lim = (int'(r_limit) > MAX_RUNNING) ? RC'(MAX_RUNNING) : RC'(r_limit);

    function automatic logic [PW-1:0] prio_of(input logic [lsps_pkg::DEV_W-1:0] d,
                                              input logic [PW-1:0] tab [MAX_DEVICES]);
        logic [PW-1:0] r;
        r = '0;
        if (32'(d) < MAX_DEVICES) r = tab[DA'(d)];
        return r;
    endfunction

    function automatic logic is_on(input lsps_pkg::t_win w, input logic [TW-1:0] t);
        return (w.start <= t) && (t < w.stop);
    endfunction

    assign i_req.ready = (r_state == lsps_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= 4'd1;
            r_policy <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.idx)
                lsps_pkg::REG_RUN_LIMIT: r_limit  <= i_cfg.data.data;
                lsps_pkg::REG_POLICY:    r_policy <= i_cfg.data.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_DEVICES; k++) r_prio[k] <= '0;
        end else if (r_pset) begin
            r_prio[r_pdev] <= r_pval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsps_pkg::S_IDLE;
            r_wcnt  <= '0;
            r_next  <= '0;
            r_rcnt  <= '0;
            r_pcnt  <= '0;
            r_ov    <= 1'b0;
            r_stg_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wcnt  <= n_wcnt;
            r_next  <= n_next;
            r_rcnt  <= n_rcnt;
            r_pcnt  <= n_pcnt;
            r_ov    <= n_ov;
            r_stg_v <= n_stg_v;
        end
        r_req <= n_req; r_i <= n_i; r_j <= n_j; r_v <= n_v;
        r_vkey_p <= n_vkey_p; r_vkey_t <= n_vkey_t; r_cur <= n_cur;
        r_vic <= n_vic; r_ret <= n_ret; r_shrun <= n_shrun; r_out <= n_out;
        r_evt <= n_evt; r_stg <= n_stg;
    end

    // priority write is a registered side effect of the priority-set item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pset <= 1'b0;
        else r_pset <= i_req.valid && i_req.ready &&
                       i_req.data.action == lsps_pkg::ACT_PRIO &&
                       32'(i_req.data.device) < MAX_DEVICES;
        r_pdev <= DA'(i_req.data.device);
        r_pval <= i_req.data.priority_req;
    end

    logic [TW-1:0] now;
    assign now = r_req.now_time;

    always_comb begin
        n_state = r_state; n_req = r_req; n_wcnt = r_wcnt; n_next = r_next;
        n_rcnt = r_rcnt; n_pcnt = r_pcnt; n_i = r_i; n_j = r_j; n_v = r_v;
        n_vkey_p = r_vkey_p; n_vkey_t = r_vkey_t; n_cur = r_cur; n_vic = r_vic;
        n_ret = r_ret; n_shrun = r_shrun; n_out = r_out;
        n_evt = r_evt; n_stg = r_stg; n_stg_v = r_stg_v;
        n_ov = r_ov;
        w_raddr = WA'(r_i); w_waddr = '0; w_we = 1'b0; w_wdata = r_wq;
        run_raddr = RA'(r_i); run_waddr = '0; run_we = 1'b0; run_wdata = r_rq;
        p_raddr = WA'(r_i); p_waddr = '0; p_we = 1'b0; p_wdata = r_pq;
        if (r_ov && o_res.ready) n_ov = 1'b0;

        unique case (r_state)
            lsps_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_req = i_req.data;
                    n_i = '0;
                    unique case (i_req.data.action)
                        lsps_pkg::ACT_PRIO: ;
                        lsps_pkg::ACT_ADD:
                            n_state = (r_wcnt >= WC'(MAX_WINDOWS)) ? lsps_pkg::S_IDLE
                                                                   : lsps_pkg::S_ADD_RD;
                        lsps_pkg::ACT_ARM: begin
                            n_next = '0; n_rcnt = '0; n_pcnt = '0;
                            n_state = lsps_pkg::S_ARM_RD;
                        end
                        default: n_state = lsps_pkg::S_RUN_RD;
                    endcase
                end
            end
            // insertion: find first strictly greater key, then shift up
            lsps_pkg::S_ADD_RD: begin
                if (r_i >= r_wcnt) begin
                    n_j = r_wcnt;
                    n_state = lsps_pkg::S_ADD_SH_RD;
                end else begin
                    w_raddr = WA'(r_i);
                    n_state = lsps_pkg::S_ADD_CMP;
                end
            end
            lsps_pkg::S_ADD_CMP: begin
                if (r_wq.start < r_req.start_time ||
                    (r_wq.start == r_req.start_time && r_wq.stop <= r_req.end_time)) begin
                    n_i = r_i + 1'b1;
                    n_state = lsps_pkg::S_ADD_RD;
                end else begin
                    n_j = r_wcnt;
                    n_state = lsps_pkg::S_ADD_SH_RD;
                end
            end
            lsps_pkg::S_ADD_SH_RD: begin
                if (r_j == r_i) begin
                    w_we = 1'b1; w_waddr = WA'(r_i);
                    w_wdata = '{dev: r_req.device, start: r_req.start_time,
                                stop: r_req.end_time};
                    n_wcnt = r_wcnt + 1'b1;
                    n_state = lsps_pkg::S_IDLE;
                end else begin
                    w_raddr = WA'(r_j - 1'b1);
                    n_state = lsps_pkg::S_ADD_SH_WR;
                end
            end
            lsps_pkg::S_ADD_SH_WR: begin
                w_we = 1'b1; w_waddr = WA'(r_j); w_wdata = r_wq;
                n_j = r_j - 1'b1;
                n_state = lsps_pkg::S_ADD_SH_RD;
            end
            lsps_pkg::S_ARM_RD: begin
                if (r_i >= r_wcnt) n_state = lsps_pkg::S_IDLE;
                else begin
                    w_raddr = WA'(r_i);
                    n_state = lsps_pkg::S_ARM_CHK;
                end
            end
            lsps_pkg::S_ARM_CHK: begin
                if (r_wq.stop > now) begin
                    n_next = WA'(r_i);
                    n_state = lsps_pkg::S_IDLE;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = lsps_pkg::S_ARM_RD;
                end
            end
            // phase 1: retire running windows that ended
            lsps_pkg::S_RUN_RD: begin
                if (r_i >= WC'(r_rcnt)) begin
                    n_i = WC'(r_next);
                    n_state = lsps_pkg::S_ACT_RD;
                end else begin
                    run_raddr = RA'(r_i);
                    n_state = lsps_pkg::S_RUN_CHK;
                end
            end
            lsps_pkg::S_RUN_CHK: begin
                if (!is_on(r_rq, now)) begin
                    n_evt = '{ev: lsps_pkg::EV_OFF, dev: r_rq.dev, last: 1'b0};
                    n_j = r_i; n_shrun = 1'b1;
                    n_ret = lsps_pkg::S_RUN_RD;
                    n_state = lsps_pkg::S_EMIT;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = lsps_pkg::S_RUN_RD;
                end
            end
            // close a gap at r_j in the running list
            lsps_pkg::S_RSH_RD: begin
                if (r_j + 1'b1 >= WC'(r_rcnt)) begin
                    n_rcnt = r_rcnt - 1'b1;
                    n_state = r_ret;
                end else begin
                    run_raddr = RA'(r_j + 1'b1);
                    n_state = lsps_pkg::S_RSH_WR;
                end
            end
            lsps_pkg::S_RSH_WR: begin
                run_we = 1'b1; run_waddr = RA'(r_j); run_wdata = r_rq;
                n_j = r_j + 1'b1;
                n_state = lsps_pkg::S_RSH_RD;
            end
            // phase 2: activations from the table pointer
            lsps_pkg::S_ACT_RD: begin
                if (r_i >= r_wcnt) begin
                    n_next = '0; n_i = '0;
                    n_state = lsps_pkg::S_PEND_RD;
                end else begin
                    w_raddr = WA'(r_i);
                    n_state = lsps_pkg::S_ACT_CHK;
                end
            end
            lsps_pkg::S_ACT_CHK: begin
                if (is_on(r_wq, now)) begin
                    if (r_pcnt < WC'(MAX_WINDOWS)) begin
                        p_we = 1'b1; p_waddr = WA'(r_pcnt); p_wdata = r_wq;
                        n_pcnt = r_pcnt + 1'b1;
                    end
                    n_i = r_i + 1'b1;
                    n_state = lsps_pkg::S_ACT_RD;
                end else begin
                    n_next = WA'(r_i); n_i = '0;
                    n_state = lsps_pkg::S_PEND_RD;
                end
            end
            // phase 3: pending list
            lsps_pkg::S_PEND_RD: begin
                if (r_i >= r_pcnt) begin
                    // a tick with no event still reports once
                    if (!r_stg_v) begin
                        n_stg = '{ev: lsps_pkg::EV_NONE, dev: '0, last: 1'b0};
                        n_stg_v = 1'b1;
                    end
                    n_state = lsps_pkg::S_DONE;
                end else begin
                    p_raddr = WA'(r_i);
                    n_state = lsps_pkg::S_PEND_CHK;
                end
            end
            lsps_pkg::S_PEND_CHK: begin
                n_cur = r_pq;
                n_j = r_i; n_shrun = 1'b0;
                if (!is_on(r_pq, now)) begin
                    n_state = lsps_pkg::S_PSH_RD;
                    n_ret = lsps_pkg::S_PEND_RD;
                end else if (r_rcnt < lim) begin
                    run_we = 1'b1; run_waddr = RA'(r_rcnt); run_wdata = r_pq;
                    n_rcnt = r_rcnt + 1'b1;
                    n_evt = '{ev: lsps_pkg::EV_ON, dev: r_pq.dev, last: 1'b0};
                    n_ret = lsps_pkg::S_PEND_RD;
                    n_state = lsps_pkg::S_EMIT;
                end else if (r_rcnt == '0) begin
                    n_i = r_i + 1'b1;
                    n_state = lsps_pkg::S_PEND_RD;
                end else begin
                    n_v = '0; n_j = '0;
                    n_state = lsps_pkg::S_VIC_RD;
                end
            end
            lsps_pkg::S_VIC_RD: begin
                if (r_j >= WC'(r_rcnt)) n_state = lsps_pkg::S_PREEMPT;
                else begin
                    run_raddr = RA'(r_j);
                    n_state = lsps_pkg::S_VIC_CHK;
                end
            end
            lsps_pkg::S_VIC_CHK: begin
                if (r_j == '0 ||
                    (!r_policy && prio_of(r_rq.dev, r_prio) < r_vkey_p) ||
                    (r_policy && r_rq.stop > r_vkey_t)) begin
                    n_v = RC'(r_j); n_vic = r_rq;
                    n_vkey_p = prio_of(r_rq.dev, r_prio);
                    n_vkey_t = r_rq.stop;
                end
                n_j = r_j + 1'b1;
                n_state = lsps_pkg::S_VIC_RD;
            end
            lsps_pkg::S_PREEMPT: begin
                if ((!r_policy && prio_of(r_cur.dev, r_prio) > r_vkey_p) ||
                    (r_policy && r_cur.stop < r_vkey_t)) begin
                    n_evt = '{ev: lsps_pkg::EV_OFF, dev: r_vic.dev, last: 1'b0};
                    n_j = WC'(r_v); n_shrun = 1'b1;
                    // after removal, append the newcomer and emit its on
                    n_ret = lsps_pkg::S_PSH_RD;
                    n_state = lsps_pkg::S_EMIT;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = lsps_pkg::S_PEND_RD;
                end
            end
            lsps_pkg::S_PSH_RD: begin
                if (r_ret == lsps_pkg::S_PSH_RD) begin
                    // arrived from preemption: running list is compacted
                    run_we = 1'b1; run_waddr = RA'(r_rcnt); run_wdata = r_cur;
                    n_rcnt = r_rcnt + 1'b1;
                    n_evt = '{ev: lsps_pkg::EV_ON, dev: r_cur.dev, last: 1'b0};
                    n_j = r_i; n_shrun = 1'b0;
                    n_ret = lsps_pkg::S_PEND_RD;
                    n_state = lsps_pkg::S_EMIT;
                end else if (r_j + 1'b1 >= r_pcnt) begin
                    n_pcnt = r_pcnt - 1'b1;
                    n_state = r_ret;
                end else begin
                    p_raddr = WA'(r_j + 1'b1);
                    n_state = lsps_pkg::S_PSH_WR;
                end
            end
            lsps_pkg::S_PSH_WR: begin
                p_we = 1'b1; p_waddr = WA'(r_j); p_wdata = r_pq;
                n_j = r_j + 1'b1;
                n_state = lsps_pkg::S_PSH_RD;
            end
            // new result: the held one is not last, so release it to the
            // output register, then hold the new one and remove the entry
            lsps_pkg::S_EMIT: begin
                if (!r_stg_v || !r_ov || o_res.ready) begin
                    if (r_stg_v) begin
                        n_out = r_stg;
                        n_ov = 1'b1;
                    end
                    n_stg = r_evt;
                    n_stg_v = 1'b1;
                    n_state = r_shrun ? lsps_pkg::S_RSH_RD : lsps_pkg::S_PSH_RD;
                end
            end
            // end of tick: the held result is the final one
            lsps_pkg::S_DONE: begin
                if (!r_ov || o_res.ready) begin
                    n_out = r_stg;
                    n_out.last = 1'b1;
                    n_ov = 1'b1;
                    n_stg_v = 1'b0;
                    n_state = lsps_pkg::S_IDLE;
                end
            end
            default: n_state = lsps_pkg::S_IDLE;
        endcase
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lsps_pkg::S_IDLE) |-> !i_req.ready)
        else $error("item accepted while busy");
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= RC'(MAX_RUNNING))
        else $error("running count overflow");
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= WC'(MAX_WINDOWS))
        else $error("pending count overflow");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(o_res.data)))
        else $error("result item changed while waiting");
`endif
endmodule
`default_nettype wire
